// File: rtl/core/mst_k_clustering_distance_defines.svh
// Assertion macros for the k-clustering spacing block.
// Used by the top level only; relies on clk_i and rst_ni in scope.
`ifndef MST_K_CLUSTERING_DISTANCE_DEFINES_SVH
`define MST_K_CLUSTERING_DISTANCE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MKC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define MKC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/mkc_pkg.sv
// Shared types and constants of the k-clustering spacing block.
// No dependencies; used by every module of the block.
package mkc_pkg;

  localparam int unsigned KW        = 11;
  localparam int unsigned XW        = 16;
  localparam int unsigned SQ_OUT_W  = 34;
  localparam int unsigned FIX_OUT_W = 33;
  localparam int unsigned FRAC_BITS = 16;
  localparam logic [KW-1:0] K_RESET = 11'd2;
  localparam logic [KW-1:0] MIN_K   = 11'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_LOAD_LAST,
    OP_BAD,
    OP_PINIT,
    OP_RDNEW,
    OP_LATNEW,
    OP_RD,
    OP_DIFF,
    OP_SQ,
    OP_UPD,
    OP_ENDR,
    OP_SINIT,
    OP_CRD,
    OP_CLAT,
    OP_JRD,
    OP_JCMP,
    OP_CCHK,
    OP_SQRT,
    OP_OUT
  } mkc_op_e;

  typedef struct packed {
    mkc_op_e op;
  } cmd_t;

  typedef struct packed {
    logic bad_k;
    logic last_v;
    logic last_round;
    logic last_j;
    logic found;
    logic sqrt_done;
  } status_t;

  typedef struct packed {
    logic signed [XW-1:0] point_x;
    logic signed [XW-1:0] point_y;
    logic                 last_point;
  } in_t;

  typedef struct packed {
    logic [SQ_OUT_W-1:0]  squared_spacing;
    logic [FIX_OUT_W-1:0] spacing_fixed;
    logic                 bad_count;
  } out_t;

endpackage

// File: rtl/core/mkc_sqrt.sv
// Digit-serial square root, one result bit per cycle, 16 fraction bits.
// Depends on mkc_pkg for the fraction width.
module mkc_sqrt
  import mkc_pkg::*;
#(
  parameter int unsigned VW = 36
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [VW-1:0]              value_i,
  output logic                       done_o,
  output logic [VW/2+FRAC_BITS-1:0]  root_o
);

  localparam int unsigned ITER = VW / 2 + FRAC_BITS;
  localparam int unsigned RMW  = ITER + 2;
  localparam int unsigned CW   = $clog2(ITER + 1);

  logic [CW-1:0]   cnt_q;
  logic            done_q;
  logic [VW-1:0]   vs_q;
  logic [RMW-1:0]  rem_q, rem_d, rs, trial;
  logic [ITER-1:0] root_q, root_d;

  always_comb begin
    rs    = {rem_q[RMW-3:0], vs_q[VW-1:VW-2]};
    trial = {root_q, 2'b01};
    if (rs >= trial) begin
      rem_d  = rs - trial;
      root_d = {root_q[ITER-2:0], 1'b1};
    end else begin
      rem_d  = rs;
      root_d = {root_q[ITER-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CW'(1));
      if (start_i) begin
        cnt_q <= CW'(ITER);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      vs_q   <= value_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (cnt_q != '0) begin
      vs_q   <= vs_q << 2;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: rtl/core/mkc_ctrl.sv
// Sequencer of the k-clustering spacing block: loading, Prim rounds,
// order-statistic selection and square root. Depends on mkc_pkg.
module mkc_ctrl
  import mkc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    last_point_i,
  input  logic    out_free_i,
  input  status_t status_i,
  output logic    in_ready_o,
  output cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_PINIT, S_RDNEW, S_LATNEW, S_RD, S_DIFF, S_SQ, S_UPD,
    S_ENDR, S_SINIT, S_CRD, S_CLAT, S_JRD, S_JCMP, S_CCHK, S_SQRT,
    S_SWAIT, S_DONE
  } state_e;

  state_e state_q;
  logic   in_fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE:   if (in_fire && last_point_i) state_q <= S_CHK;
        S_CHK:    state_q <= status_i.bad_k ? S_SQRT : S_PINIT;
        S_PINIT:  state_q <= S_RDNEW;
        S_RDNEW:  state_q <= S_LATNEW;
        S_LATNEW: state_q <= S_RD;
        S_RD:     state_q <= S_DIFF;
        S_DIFF:   state_q <= S_SQ;
        S_SQ:     state_q <= S_UPD;
        S_UPD:    state_q <= status_i.last_v ? S_ENDR : S_RD;
        S_ENDR:   state_q <= status_i.last_round ? S_SINIT : S_RDNEW;
        S_SINIT:  state_q <= S_CRD;
        S_CRD:    state_q <= S_CLAT;
        S_CLAT:   state_q <= S_JRD;
        S_JRD:    state_q <= S_JCMP;
        S_JCMP:   state_q <= status_i.last_j ? S_CCHK : S_JRD;
        S_CCHK:   state_q <= status_i.found ? S_SQRT : S_CRD;
        S_SQRT:   state_q <= S_SWAIT;
        S_SWAIT:  if (status_i.sqrt_done) state_q <= S_DONE;
        S_DONE:   if (out_free_i) state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.op = OP_NONE;
    unique case (state_q)
      S_IDLE:   if (in_fire) cmd_o.op = last_point_i ? OP_LOAD_LAST : OP_LOAD;
      S_CHK:    cmd_o.op = status_i.bad_k ? OP_BAD : OP_NONE;
      S_PINIT:  cmd_o.op = OP_PINIT;
      S_RDNEW:  cmd_o.op = OP_RDNEW;
      S_LATNEW: cmd_o.op = OP_LATNEW;
      S_RD:     cmd_o.op = OP_RD;
      S_DIFF:   cmd_o.op = OP_DIFF;
      S_SQ:     cmd_o.op = OP_SQ;
      S_UPD:    cmd_o.op = OP_UPD;
      S_ENDR:   cmd_o.op = OP_ENDR;
      S_SINIT:  cmd_o.op = OP_SINIT;
      S_CRD:    cmd_o.op = OP_CRD;
      S_CLAT:   cmd_o.op = OP_CLAT;
      S_JRD:    cmd_o.op = OP_JRD;
      S_JCMP:   cmd_o.op = OP_JCMP;
      S_CCHK:   cmd_o.op = OP_CCHK;
      S_SQRT:   cmd_o.op = OP_SQRT;
      S_SWAIT:  cmd_o.op = OP_NONE;
      S_DONE:   if (out_free_i) cmd_o.op = OP_OUT;
      default:  cmd_o.op = OP_NONE;
    endcase
  end

endmodule

// File: rtl/core/mkc_dpath.sv
// Datapath: point stores, Prim distance memory, tree weights, selection
// counters and the square-root unit. Depends on mkc_pkg and mkc_sqrt.
module mkc_dpath
  import mkc_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cmd_t                          cmd_i,
  input  in_t                           in_data_i,
  input  logic                          cfg_we_i,
  input  logic [KW-1:0]                 cfg_data_i,
  output status_t                       status_o,
  output logic [2*COORD_BITS+2:0]       res_sq_o,
  output logic                          res_bad_o,
  output logic [COORD_BITS+FRAC_BITS+1:0] res_root_o
);

  localparam int unsigned IW   = $clog2(MAX_POINTS);
  localparam int unsigned CNTW = $clog2(MAX_POINTS + 1);
  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned DW   = CB + 1;
  localparam int unsigned SUMW = 2 * DW + 1;

  logic signed [CB-1:0] x_mem [MAX_POINTS];
  logic signed [CB-1:0] y_mem [MAX_POINTS];
  logic [SUMW-1:0]      dist_mem [MAX_POINTS];
  logic [SUMW-1:0]      w_mem [MAX_POINTS];

  logic [KW-1:0]   k_q;
  logic [CNTW-1:0] cnt_q, n_q, t_q, lt_q, le_q;
  logic            full;
  logic [CB+XW-1:0] px_ext, py_ext;

  logic signed [CB-1:0] x_rd_q, y_rd_q, nx_q, ny_q;
  logic [SUMW-1:0]      dist_rd_q, w_rd_q, min_q, cw_q, d, nd;
  logic signed [DW-1:0] dx_q, dy_q;
  logic [2*DW-1:0]      sqx_q, sqy_q;
  logic [MAX_POINTS-1:0] in_tree_q;
  logic [IW-1:0]        v_q, new_q, arg_q, round_q, cand_q, j_q, xy_addr, w_addr;
  logic                 first_q;
  logic [SUMW-1:0]      res_sq_q;
  logic                 res_bad_q;
  logic                 sqrt_done;

  assign full   = (cnt_q == CNTW'(MAX_POINTS));
  assign px_ext = {{CB{1'b0}}, in_data_i.point_x};
  assign py_ext = {{CB{1'b0}}, in_data_i.point_y};

  // Control registers: point count and the cluster count register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      k_q   <= K_RESET;
    end else begin
      if (cfg_we_i) k_q <= cfg_data_i;
      if (cmd_i.op == OP_LOAD_LAST) begin
        cnt_q <= '0;
      end else if (cmd_i.op == OP_LOAD && !full) begin
        cnt_q <= cnt_q + CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((cmd_i.op == OP_LOAD || cmd_i.op == OP_LOAD_LAST) && !full) begin
      x_mem[cnt_q[IW-1:0]] <= px_ext[CB-1:0];
      y_mem[cnt_q[IW-1:0]] <= py_ext[CB-1:0];
    end
    if (cmd_i.op == OP_LOAD_LAST) begin
      n_q <= full ? cnt_q : cnt_q + CNTW'(1);
    end
  end

  assign xy_addr = (cmd_i.op == OP_RDNEW) ? new_q : v_q;
  assign w_addr  = (cmd_i.op == OP_CRD) ? cand_q : j_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_RD || cmd_i.op == OP_RDNEW) begin
      x_rd_q <= x_mem[xy_addr];
      y_rd_q <= y_mem[xy_addr];
    end
    if (cmd_i.op == OP_RD) dist_rd_q <= dist_mem[v_q];
    if (cmd_i.op == OP_CRD || cmd_i.op == OP_JRD) w_rd_q <= w_mem[w_addr];
    if (cmd_i.op == OP_UPD && !in_tree_q[v_q]) dist_mem[v_q] <= nd;
    if (cmd_i.op == OP_ENDR) w_mem[round_q] <= min_q;
  end

  assign d  = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign nd = (first_q || d < dist_rd_q) ? d : dist_rd_q;

  // Prim rounds, selection counters and the result registers.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_PINIT: begin
        new_q     <= '0;
        in_tree_q <= MAX_POINTS'(1);
        first_q   <= 1'b1;
        round_q   <= '0;
      end
      OP_LATNEW: begin
        nx_q  <= x_rd_q;
        ny_q  <= y_rd_q;
        v_q   <= '0;
        min_q <= '1;
      end
      OP_DIFF: begin
        dx_q <= $signed({x_rd_q[CB-1], x_rd_q}) - $signed({nx_q[CB-1], nx_q});
        dy_q <= $signed({y_rd_q[CB-1], y_rd_q}) - $signed({ny_q[CB-1], ny_q});
      end
      OP_SQ: begin
        // The product is formed at full width; a square is never negative.
        sqx_q <= (2*DW)'(dx_q * dx_q);
        sqy_q <= (2*DW)'(dy_q * dy_q);
      end
      OP_UPD: begin
        if (!in_tree_q[v_q] && nd < min_q) begin
          min_q <= nd;
          arg_q <= v_q;
        end
        v_q <= v_q + IW'(1);
      end
      OP_ENDR: begin
        in_tree_q[arg_q] <= 1'b1;
        new_q            <= arg_q;
        round_q          <= round_q + IW'(1);
        first_q          <= 1'b0;
      end
      OP_SINIT: begin
        cand_q <= '0;
        t_q    <= n_q - CNTW'(k_q);
      end
      OP_CLAT: begin
        cw_q <= w_rd_q;
        j_q  <= '0;
        lt_q <= '0;
        le_q <= '0;
      end
      OP_JCMP: begin
        if (w_rd_q < cw_q)  lt_q <= lt_q + CNTW'(1);
        if (w_rd_q <= cw_q) le_q <= le_q + CNTW'(1);
        j_q <= j_q + IW'(1);
      end
      OP_CCHK: begin
        if (status_o.found) begin
          res_sq_q  <= cw_q;
          res_bad_q <= 1'b0;
        end else begin
          cand_q <= cand_q + IW'(1);
        end
      end
      OP_BAD: begin
        res_sq_q  <= '0;
        res_bad_q <= 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    status_o.bad_k      = (k_q < MIN_K) || (k_q > KW'(n_q));
    status_o.last_v     = (CNTW'(v_q) + CNTW'(1) == n_q);
    status_o.last_round = (CNTW'(round_q) + CNTW'(2) == n_q);
    status_o.last_j     = (CNTW'(j_q) + CNTW'(2) == n_q);
    status_o.found      = (lt_q <= t_q) && (t_q < le_q);
    status_o.sqrt_done  = sqrt_done;
  end

  mkc_sqrt #(
    .VW(SUMW + 1)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.op == OP_SQRT),
    .value_i ({1'b0, res_sq_q}),
    .done_o  (sqrt_done),
    .root_o  (res_root_o)
  );

  assign res_sq_o  = res_sq_q;
  assign res_bad_o = res_bad_q;

endmodule

// File: rtl/core/mst_k_clustering_distance.sv
// After the last point of a set, the Prim rounds, the selection pass and
// the square root run one after another before the result appears; the
// shared distance unit and the single read port of the tree-weight memory
// keep each pass serial.
// Throughput: one set at a time; points stream at one per cycle between sets.
// Reset: cluster count 2, no points loaded, no result pending; no clearing pass.
module mst_k_clustering_distance
  import mkc_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 64,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  in_t           in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output out_t          out_data_o,
  input  logic          cfg_we_i,
  input  logic [KW-1:0] cfg_data_i
);

`include "mst_k_clustering_distance_defines.svh"

  localparam int unsigned SUMW = 2 * COORD_BITS + 3;
  localparam int unsigned RW   = COORD_BITS + FRAC_BITS + 2;

  cmd_t            cmd;
  status_t         status;
  logic [SUMW-1:0] res_sq;
  logic [RW-1:0]   res_root;
  logic            res_bad;
  logic            out_free;
  logic            out_valid_q;
  out_t            out_q;
  // Wide staging words so that the result fields are masked to their widths.
  logic [SUMW+SQ_OUT_W-1:0] sq_ext;
  logic [RW+FIX_OUT_W-1:0]  root_ext;

  // The output register can take a new request when empty or being drained.
  assign out_free = !out_valid_q || out_ready_i;
  assign sq_ext   = {{SQ_OUT_W{1'b0}}, res_sq};
  assign root_ext = {{FIX_OUT_W{1'b0}}, res_root};

  mkc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_point_i (in_data_i.last_point),
    .out_free_i   (out_free),
    .status_i     (status),
    .in_ready_o   (in_ready_o),
    .cmd_o        (cmd)
  );

  mkc_dpath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .status_o   (status),
    .res_sq_o   (res_sq),
    .res_bad_o  (res_bad),
    .res_root_o (res_root)
  );

  // Output register: holds the result request until the consumer takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.op == OP_OUT) begin
      out_q.squared_spacing <= sq_ext[SQ_OUT_W-1:0];
      out_q.spacing_fixed   <= root_ext[FIX_OUT_W-1:0];
      out_q.bad_count       <= res_bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `MKC_ASSERT_NOW(a_out_load_free, cmd.op == OP_OUT, !out_valid_q || out_ready_i,
    "result loaded over a pending request")
  `MKC_ASSERT_NEXT(a_out_load_valid, cmd.op == OP_OUT, out_valid_o,
    "loaded result not presented")
  `MKC_ASSERT_NOW(a_bad_zero, out_valid_o && out_data_o.bad_count,
    out_data_o.squared_spacing == '0 && out_data_o.spacing_fixed == '0,
    "bad cluster count with nonzero spacing")

endmodule

// File: sim/mkc_spacing_checker.sv
// Checker for the k-clustering spacing block: watches both request channels,
// predicts each result with its own Kruskal spacing model and compares it.
// Depends on mkc_pkg; instantiated by tb_mst_k_clustering_distance.
module mkc_spacing_checker
  import mkc_pkg::*;
#(
  parameter int unsigned MAX_POINTS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  in_t           in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  out_t          out_data_i,
  input  logic          cfg_we_i,
  input  logic [KW-1:0] cfg_data_i,
  output int            fail_count_o,
  output int            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPAIR = MAX_POINTS * (MAX_POINTS - 1) / 2;

  longint    px [MAX_POINTS];
  longint    py [MAX_POINTS];
  int        n_loaded;
  int        k_cfg;
  out_t      spacing_q [$];

  function automatic longint unsigned fixed_root(longint unsigned v);
    longint unsigned root, rem, trial, two;
    root = 0;
    rem = 0;
    for (int p = 41; p >= 0; p--) begin
      two = (p >= 16) ? ((v >> (2 * (p - 16))) & 3) : 0;
      rem = (rem << 2) | two;
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // Kruskal over all pairs; the (k-1)th largest tree edge is returned.
  function automatic longint unsigned tree_spacing(int n, int k);
    longint unsigned w [NPAIR];
    int              ea [NPAIR];
    int              eb [NPAIR];
    int              parent [MAX_POINTS];
    int              rnk [MAX_POINTS];
    longint unsigned kept [MAX_POINTS];
    longint unsigned tw;
    longint          dx, dy;
    int              ne, nk, ra, rb, ta, tsb, j;
    ne = 0;
    nk = 0;
    for (int i = 0; i < n; i++) begin
      parent[i] = i;
      rnk[i] = 0;
      for (int q = i + 1; q < n; q++) begin
        dx = px[i] - px[q];
        dy = py[i] - py[q];
        w[ne] = dx * dx + dy * dy;
        ea[ne] = i;
        eb[ne] = q;
        ne++;
      end
    end
    // Stable insertion sort by ascending weight.
    for (int i = 1; i < ne; i++) begin
      tw = w[i];
      ta = ea[i];
      tsb = eb[i];
      j = i;
      while (j > 0 && w[j - 1] > tw) begin
        w[j] = w[j - 1];
        ea[j] = ea[j - 1];
        eb[j] = eb[j - 1];
        j--;
      end
      w[j] = tw;
      ea[j] = ta;
      eb[j] = tsb;
    end
    for (int e = 0; e < ne && nk + 1 < n; e++) begin
      ra = ea[e];
      while (parent[ra] != ra) ra = parent[ra];
      rb = eb[e];
      while (parent[rb] != rb) rb = parent[rb];
      if (ra != rb) begin
        kept[nk] = w[e];
        nk++;
        if (rnk[ra] > rnk[rb]) begin
          parent[rb] = ra;
        end else begin
          parent[ra] = rb;
          if (rnk[ra] == rnk[rb]) rnk[rb]++;
        end
      end
    end
    return kept[n - k];
  endfunction

  assign pending_o = spacing_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_t            want;
    out_t            got;
    longint unsigned sq;
    longint unsigned rt;
    int              errs;
    errs = 0;
    if (!rst_ni) begin
      n_loaded <= 0;
      k_cfg <= int'(K_RESET);
      fail_count_o <= 0;
      spacing_q.delete();
    end else begin
      if (cfg_we_i) k_cfg <= int'(cfg_data_i);
      if (in_valid_i && in_ready_i) begin
        automatic int n = n_loaded;
        if (n < MAX_POINTS) begin
          px[n] = longint'(in_data_i.point_x);
          py[n] = longint'(in_data_i.point_y);
          n++;
        end
        if (in_data_i.last_point) begin
          want = '0;
          if (k_cfg < 2 || k_cfg > n) begin
            want.bad_count = 1'b1;
          end else begin
            sq = tree_spacing(n, k_cfg);
            rt = fixed_root(sq);
            want.squared_spacing = sq[SQ_OUT_W-1:0];
            want.spacing_fixed = rt[FIX_OUT_W-1:0];
          end
          spacing_q.insert(spacing_q.size(), want);
          n = 0;
        end
        n_loaded <= n;
      end
      if (out_valid_i && out_ready_i) begin
        got = out_data_i;
        if (spacing_q.size() == 0) begin
          $error("result with no request pending");
          errs++;
        end else begin
          want = spacing_q.pop_front();
          if (got.squared_spacing !== want.squared_spacing) begin
            $error("squared_spacing: expected %0d, got %0d",
                   want.squared_spacing, got.squared_spacing);
            errs++;
          end
          if (got.spacing_fixed !== want.spacing_fixed) begin
            $error("spacing_fixed: expected %0d, got %0d",
                   want.spacing_fixed, got.spacing_fixed);
            errs++;
          end
          if (got.bad_count !== want.bad_count) begin
            $error("bad_count: expected %0d, got %0d", want.bad_count, got.bad_count);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count_o <= fail_count_o + errs;
    end
  end
endmodule

// File: sim/tb_mst_k_clustering_distance.sv
// Testbench top for the k-clustering spacing block: makes point requests,
// cluster-count writes and output stalls; the checker does the prediction.
// Depends on mkc_pkg, mst_k_clustering_distance and mkc_spacing_checker.
module tb_mst_k_clustering_distance;
  import mkc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXP = 64;
  // The limit must cover the worst set of 64 points, Prim rounds plus
  // selection, before the block is called hung.
  localparam int WATCHDOG_LIMIT = 200000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  in_t           in_data_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  out_t          out_data_o;
  logic          cfg_we_i = 1'b0;
  logic [KW-1:0] cfg_data_i = '0;
  int            fail_count;
  int            pending;
  int            idle_cycles = 0;
  int            points_sent = 0;
  bit            stim_done = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  mst_k_clustering_distance #(.MAX_POINTS(MAXP), .COORD_BITS(16)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  mkc_spacing_checker #(.MAX_POINTS(MAXP)) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_i  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // The receiver inserts random stalls before taking each result.
  initial begin
    int gap;
    forever begin
      gap = $urandom_range(3);
      repeat (gap) @(posedge clk_i);
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      out_ready_i <= 1'b0;
    end
  end

  // Watchdog: any accepted request on either channel resets the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Send one point request. The valid is dropped only when the next request
  // has a gap, so valid never toggles twice within a time step.
  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic last);
    int gap;
    gap = $urandom_range(3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{point_x: x, point_y: y, last_point: last};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    points_sent++;
  endtask

  // Load a set of n points; the last one closes it. Small sets keep the
  // Kruskal phase short. When spread is zero the coordinates span the full
  // 16-bit range, otherwise they cluster to produce ties and short edges.
  task automatic send_set(input int n, input int spread);
    logic signed [15:0] x, y;
    for (int i = 0; i < n; i++) begin
      if (spread == 0) begin
        x = 16'($urandom);
        y = 16'($urandom);
      end else begin
        x = 16'($urandom_range(spread) - spread / 2);
        y = 16'($urandom_range(spread) - spread / 2);
      end
      send_point(x, y, i == n - 1);
    end
  endtask

  // The cluster count is written only with every result drained and the
  // block back in its loading state.
  task automatic write_k(input int k);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= KW'(k);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int n, k;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset k of 2 on extreme corners, which gives the longest
    // squared distance the fields allow.
    send_point(-16'sd32768, -16'sd32768, 1'b0);
    send_point(16'sd32767, 16'sd32767, 1'b1);
    // A single point always has too few points for any k.
    send_point(16'sd5, -16'sd7, 1'b1);
    // Coincident points put a zero-weight edge in the tree, below the spacing for k of 2.
    send_point(16'sd100, 16'sd100, 1'b0);
    send_point(16'sd100, 16'sd100, 1'b0);
    send_point(-16'sd1, 16'sd0, 1'b1);
    // k of 0 and 1 are both bad counts.
    write_k(0);
    send_set(3, 0);
    write_k(1);
    send_set(2, 0);
    // k equal to the point count picks the shortest tree edge.
    write_k(4);
    send_set(4, 50);
    send_set(3, 0);
    // Largest k; also overfills the set so the extra points get dropped
    // while the last marker still starts the computation.
    write_k(2047);
    send_set(5, 0);
    write_k(MAXP);
    send_set(MAXP + 3, 0);

    // Random phase: sets of mostly small size under changing k values.
    while (points_sent < 1000) begin
      case ($urandom_range(7))
        0: k = $urandom_range(2047);
        1: k = $urandom_range(1);
        default: k = $urandom_range(2, 6);
      endcase
      write_k(k);
      repeat ($urandom_range(2, 6)) begin
        n = ($urandom_range(15) == 0) ? $urandom_range(MAXP - 8, MAXP + 2)
                                      : $urandom_range(1, 8);
        send_set(n, ($urandom_range(1) == 0) ? 0 : 20);
      end
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

// File: mst_k_clustering_distance.f
+incdir+rtl/core
rtl/core/mkc_pkg.sv
rtl/core/mkc_sqrt.sv
rtl/core/mkc_ctrl.sv
rtl/core/mkc_dpath.sv
rtl/core/mst_k_clustering_distance.sv
sim/mkc_spacing_checker.sv
sim/tb_mst_k_clustering_distance.sv
